FILE: rtl/c6502_pkg.sv
// Shared types, opcode decode and constants for the 6502 subset core.
package c6502_pkg;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_EXEC  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    M_IMP, M_IMM, M_ZP, M_ZPX, M_ZPY, M_ABS, M_ABX, M_ABY, M_INX, M_INY
  } mode_t;

  typedef enum logic [3:0] {
    O_LDA, O_LDX, O_LDY, O_STA, O_STX, O_STY,
    O_TAX, O_TXA, O_TAY, O_TYA, O_ADC, O_SBC, O_BAD
  } oper_t;

  typedef enum logic [3:0] {
    S_IDLE, S_HRD, S_OPC, S_OP1, S_OP2, S_PLO, S_PHI, S_EXEC, S_DONE
  } state_t;

  typedef struct packed {
    oper_t oper;
    mode_t mode;
  } dec_t;

  typedef struct packed {
    logic [7:0] value;
    logic [7:0] flags;
  } alu_res_t;

  localparam logic [7:0]  FLAG_N      = 8'h80;
  localparam logic [7:0]  FLAG_V      = 8'h40;
  localparam logic [7:0]  FLAG_Z      = 8'h02;
  localparam logic [7:0]  FLAG_C      = 8'h01;
  localparam logic [7:0]  FLAG_MASK   = 8'hC3;
  localparam logic [15:0] START_RESET = 16'h8000;

  function automatic dec_t decode(input logic [7:0] op);
    dec_t d;
    d.oper = O_BAD;
    d.mode = M_IMP;
    unique case (op)
      8'hA9: d = '{O_LDA, M_IMM};
      8'hA5: d = '{O_LDA, M_ZP};
      8'hB5: d = '{O_LDA, M_ZPX};
      8'hAD: d = '{O_LDA, M_ABS};
      8'hBD: d = '{O_LDA, M_ABX};
      8'hB9: d = '{O_LDA, M_ABY};
      8'hA1: d = '{O_LDA, M_INX};
      8'hB1: d = '{O_LDA, M_INY};
      8'hA2: d = '{O_LDX, M_IMM};
      8'hA6: d = '{O_LDX, M_ZP};
      8'hB6: d = '{O_LDX, M_ZPY};
      8'hAE: d = '{O_LDX, M_ABS};
      8'hBE: d = '{O_LDX, M_ABY};
      8'hA0: d = '{O_LDY, M_IMM};
      8'hA4: d = '{O_LDY, M_ZP};
      8'hB4: d = '{O_LDY, M_ZPX};
      8'hAC: d = '{O_LDY, M_ABS};
      8'hBC: d = '{O_LDY, M_ABX};
      8'h85: d = '{O_STA, M_ZP};
      8'h95: d = '{O_STA, M_ZPX};
      8'h8D: d = '{O_STA, M_ABS};
      8'h9D: d = '{O_STA, M_ABX};
      8'h99: d = '{O_STA, M_ABY};
      8'h81: d = '{O_STA, M_INX};
      8'h91: d = '{O_STA, M_INY};
      8'h86: d = '{O_STX, M_ZP};
      8'h96: d = '{O_STX, M_ZPY};
      8'h8E: d = '{O_STX, M_ABS};
      8'h84: d = '{O_STY, M_ZP};
      8'h94: d = '{O_STY, M_ZPX};
      8'h8C: d = '{O_STY, M_ABS};
      8'hAA: d = '{O_TAX, M_IMP};
      8'h8A: d = '{O_TXA, M_IMP};
      8'hA8: d = '{O_TAY, M_IMP};
      8'h98: d = '{O_TYA, M_IMP};
      8'h69: d = '{O_ADC, M_IMM};
      8'h65: d = '{O_ADC, M_ZP};
      8'h75: d = '{O_ADC, M_ZPX};
      8'h6D: d = '{O_ADC, M_ABS};
      8'h7D: d = '{O_ADC, M_ABX};
      8'h79: d = '{O_ADC, M_ABY};
      8'h61: d = '{O_ADC, M_INX};
      8'h71: d = '{O_ADC, M_INY};
      8'hE9: d = '{O_SBC, M_IMM};
      default: d = '{O_BAD, M_IMP};
    endcase
    return d;
  endfunction

endpackage

FILE: rtl/c6502_mem.sv
// Byte-wide synchronous main memory with one shared address port.
module c6502_mem import c6502_pkg::*; #(
  parameter int ADDR_BITS = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] addr,
  input  logic [7:0]           wdata,
  output logic [7:0]           rdata
);

  logic [7:0] mem [0:(1<<ADDR_BITS)-1];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/c6502_alu.sv
// Result and flag logic for loads, transfers, ADC and SBC.
module c6502_alu import c6502_pkg::*; (
  input  oper_t      oper,
  input  logic [7:0] acc,
  input  logic [7:0] operand,
  input  logic [7:0] flags_in,
  output alu_res_t   res
);

  logic [7:0] m;
  logic [8:0] sum;
  logic [7:0] r;
  logic [7:0] f;

  always_comb begin
    m   = (oper == O_SBC) ? ~operand : operand;
    sum = {1'b0, acc} + {1'b0, m} + {8'd0, flags_in[0]};
    f   = flags_in & FLAG_MASK;
    if (oper == O_ADC || oper == O_SBC) begin
      r = sum[7:0];
      f = f & ~(FLAG_C | FLAG_V);
      if (sum[8]) begin
        f = f | FLAG_C;
      end
      if (((acc ^ r) & (m ^ r) & 8'h80) != 8'd0) begin
        f = f | FLAG_V;
      end
    end else begin
      r = operand;
    end
    f = f & ~(FLAG_N | FLAG_Z);
    if (r == 8'd0) begin
      f = f | FLAG_Z;
    end
    if (r[7]) begin
      f = f | FLAG_N;
    end
    res.value = r;
    res.flags = f;
  end

endmodule

FILE: rtl/cpu_6502_subset_core.sv
// Top level of the 6502 subset core: sequencer, registers and result port.
//
//   channel  direction  handshake            word
//   in_      into core  in_valid / in_stall  command, address, data
//   out_     out        out_valid/out_stall  A, X, Y, PC, flags, read data, fault
//   cfg_     into core  cfg_write_en         start address
//
// Host writes, host reads and instructions step through the sequencer states,
// which issue the accesses of the single memory port in turn (opcode, operands, pointer, data).
// One word is worked on at a time; a result waiting at the output does not
// block the next word unless a second result would overwrite it.
// After reset the program counter is loaded from start_address, and no word
// is accepted while it loads. Memory contents are not cleared.
module cpu_6502_subset_core import c6502_pkg::*; #(
  parameter int ADDR_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_write_en,
  input  logic [15:0] cfg_write_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [15:0] in_address,
  input  logic [7:0]  in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_accumulator,
  output logic [7:0]  out_index_x,
  output logic [7:0]  out_index_y,
  output logic [15:0] out_program_counter,
  output logic [7:0]  out_flags,
  output logic [7:0]  out_read_data,
  output logic        out_fault
);

  state_t state_r, state_nxt;
  logic [15:0] start_address_r;
  logic pc_load_r, pc_load_nxt;
  logic [15:0] pc_r, pc_nxt;
  logic [7:0] a_r, a_nxt, x_r, x_nxt, y_r, y_nxt, p_r, p_nxt;
  oper_t oper_r, oper_nxt;
  mode_t mode_r, mode_nxt;
  logic [7:0] lo_r, lo_nxt, ptr_r, ptr_nxt;
  logic [7:0] rd_r, rd_nxt;
  logic fault_r, fault_nxt;
  logic out_valid_r, out_valid_nxt, out_load;
  logic [7:0] o_a_r, o_x_r, o_y_r, o_p_r, o_rd_r;
  logic [15:0] o_pc_r;
  logic o_fault_r;

  logic mem_we;
  logic [ADDR_BITS-1:0] mem_addr;
  logic [7:0] mem_wdata, mem_rdata;
  logic [7:0] alu_operand;
  alu_res_t alu_res;

  c6502_mem #(.ADDR_BITS(ADDR_BITS)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  c6502_alu u_alu (
    .oper     (oper_r),
    .acc      (a_r),
    .operand  (alu_operand),
    .flags_in (p_r),
    .res      (alu_res)
  );

  assign in_stall = (state_r != S_IDLE) || pc_load_r;

  always_comb begin
    unique case (oper_r)
      O_TAX, O_TAY: alu_operand = a_r;
      O_TXA:        alu_operand = x_r;
      O_TYA:        alu_operand = y_r;
      default:      alu_operand = mem_rdata;
    endcase
  end

  always_comb begin
    dec_t       dec;
    logic [15:0] ea;
    logic        ea_go;
    state_nxt   = state_r;
    pc_load_nxt = pc_load_r;
    pc_nxt      = pc_r;
    a_nxt       = a_r;
    x_nxt       = x_r;
    y_nxt       = y_r;
    p_nxt       = p_r;
    oper_nxt    = oper_r;
    mode_nxt    = mode_r;
    lo_nxt      = lo_r;
    ptr_nxt     = ptr_r;
    rd_nxt      = rd_r;
    fault_nxt   = fault_r;
    mem_we      = 1'b0;
    mem_addr    = pc_r[ADDR_BITS-1:0];
    mem_wdata   = in_data;
    out_load    = 1'b0;
    dec         = decode(mem_rdata);
    ea          = 16'd0;
    ea_go       = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (pc_load_r) begin
          pc_nxt      = start_address_r;
          pc_load_nxt = 1'b0;
        end else if (in_valid) begin
          rd_nxt    = 8'd0;
          fault_nxt = 1'b0;
          unique case (cmd_t'(in_command))
            CMD_WRITE: begin
              mem_we    = 1'b1;
              mem_addr  = in_address[ADDR_BITS-1:0];
              state_nxt = S_DONE;
            end
            CMD_READ: begin
              mem_addr  = in_address[ADDR_BITS-1:0];
              state_nxt = S_HRD;
            end
            CMD_EXEC: begin
              pc_nxt    = pc_r + 16'd1;
              state_nxt = S_OPC;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_HRD: begin
        rd_nxt    = mem_rdata;
        state_nxt = S_DONE;
      end
      S_OPC: begin
        oper_nxt = dec.oper;
        mode_nxt = dec.mode;
        if (dec.oper == O_BAD) begin
          fault_nxt = 1'b1;
          state_nxt = S_DONE;
        end else if (dec.mode == M_IMP) begin
          state_nxt = S_EXEC;
        end else begin
          pc_nxt    = pc_r + 16'd1;
          state_nxt = (dec.mode == M_IMM) ? S_EXEC : S_OP1;
        end
      end
      S_OP1: begin
        unique case (mode_r)
          M_ZP: begin
            ea = {8'd0, mem_rdata};
            ea_go = 1'b1;
          end
          M_ZPX: begin
            ea = {8'd0, mem_rdata + x_r};
            ea_go = 1'b1;
          end
          M_ZPY: begin
            ea = {8'd0, mem_rdata + y_r};
            ea_go = 1'b1;
          end
          M_INX, M_INY: begin
            ptr_nxt   = (mode_r == M_INX) ? mem_rdata + x_r : mem_rdata;
            mem_addr  = ADDR_BITS'({8'd0, ptr_nxt});
            state_nxt = S_PLO;
          end
          default: begin
            lo_nxt    = mem_rdata;
            pc_nxt    = pc_r + 16'd1;
            state_nxt = S_OP2;
          end
        endcase
      end
      S_OP2: begin
        ea = {mem_rdata, lo_r};
        if (mode_r == M_ABX) begin
          ea = ea + {8'd0, x_r};
        end else if (mode_r == M_ABY) begin
          ea = ea + {8'd0, y_r};
        end
        ea_go = 1'b1;
      end
      S_PLO: begin
        lo_nxt    = mem_rdata;
        mem_addr  = ADDR_BITS'({8'd0, ptr_r + 8'd1});
        state_nxt = S_PHI;
      end
      S_PHI: begin
        ea = {mem_rdata, lo_r};
        if (mode_r == M_INY) begin
          ea = ea + {8'd0, y_r};
        end
        ea_go = 1'b1;
      end
      S_EXEC: begin
        p_nxt = alu_res.flags;
        unique case (oper_r)
          O_LDX, O_TAX: x_nxt = alu_res.value;
          O_LDY, O_TAY: y_nxt = alu_res.value;
          default:      a_nxt = alu_res.value;
        endcase
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // Effective address known: a store writes now, anything else reads it.
    if (ea_go) begin
      mem_addr = ea[ADDR_BITS-1:0];
      if (oper_r == O_STA || oper_r == O_STX || oper_r == O_STY) begin
        mem_we    = 1'b1;
        mem_wdata = (oper_r == O_STA) ? a_r : (oper_r == O_STX) ? x_r : y_r;
        state_nxt = S_DONE;
      end else begin
        state_nxt = S_EXEC;
      end
    end
  end

  assign out_valid_nxt = out_load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      start_address_r <= START_RESET;
      pc_load_r       <= 1'b1;
      pc_r            <= START_RESET;
      a_r             <= 8'd0;
      x_r             <= 8'd0;
      y_r             <= 8'd0;
      p_r             <= 8'd0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pc_load_r   <= pc_load_nxt;
      pc_r        <= pc_nxt;
      a_r         <= a_nxt;
      x_r         <= x_nxt;
      y_r         <= y_nxt;
      p_r         <= p_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_write_en) begin
        start_address_r <= cfg_write_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    oper_r  <= oper_nxt;
    mode_r  <= mode_nxt;
    lo_r    <= lo_nxt;
    ptr_r   <= ptr_nxt;
    rd_r    <= rd_nxt;
    fault_r <= fault_nxt;
    if (out_load) begin
      o_a_r     <= a_r;
      o_x_r     <= x_r;
      o_y_r     <= y_r;
      o_pc_r    <= pc_r;
      o_p_r     <= p_r & FLAG_MASK;
      o_rd_r    <= rd_r;
      o_fault_r <= fault_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_accumulator     = o_a_r;
  assign out_index_x         = o_x_r;
  assign out_index_y         = o_y_r;
  assign out_program_counter = o_pc_r;
  assign out_flags           = o_p_r;
  assign out_read_data       = o_rd_r;
  assign out_fault           = o_fault_r;

endmodule

FILE: rtl/c6502_checker.sv
// Port-level checks for the 6502 subset core and their bind.
module c6502_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_flags,
  input logic [7:0] out_read_data,
  input logic       out_fault
);

  // Only N, V, Z and C can ever be set in a result word.
  a_flag_bits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_flags[5:2] == 4'd0) else $error("reserved flag bit set");

  // A faulting instruction never returns memory data.
  a_fault_rd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fault |-> out_read_data == 8'd0) else $error("fault with read data");

  // Each accepted word moves the sequencer out of idle, so the input stalls right after it.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall) else $error("accepted two words back to back");

  // A stalled result word keeps its valid.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid) else $error("result dropped under stall");

endmodule

bind cpu_6502_subset_core c6502_checker u_c6502_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_flags     (out_flags),
  .out_read_data (out_read_data),
  .out_fault     (out_fault)
);
